/* src/brb_pkg.sv */
// Shared types and constants for the byte ring buffer.
package brb_pkg;

    localparam int CountW     = 7;
    localparam int ByteW      = 8;
    localparam int StatW      = 11;
    localparam int MaxResults = 64;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_DROP   = 2'd2,
        OP_STATUS = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_DROP_RESP
    } t_state;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             byte_valid;
        logic             last;
        logic             accepted;
        logic [StatW-1:0] fill_level;
        logic [StatW-1:0] free_space;
        logic [StatW-1:0] contiguous;
    } t_result;

endpackage

/* src/byte_ring_buffer.sv */
// Top level of the circular byte FIFO with its output register.
//
// Usage: one operation per transaction on the slave stream. tuser carries the
// opcode (push, pop, drop, status); tdata carries the push byte and the count.
// Each operation yields one transaction on the master stream, except a pop of
// n bytes (n clamped to the fill and to 64) which yields n, the final one with
// tlast set. A pop of nothing yields a single transaction with tuser low.
// Every result carries fill level, free space and contiguous bytes before wrap.
//
// Order: push, status and empty pop appear on the master side in the cycle after
// acceptance; drop passes through the drop response state first. A pop reads
// each byte into the store's read register, then into the output register.
// Throughput: one push or status per cycle while the master side takes results.
// Reset clears both pointers and the fill; the store contents are not cleared
// and no byte is read before it was written.
// When the master side stalls, the finished result holds in the output register
// and the slave side keeps tready low until the register can be refilled.
module byte_ring_buffer #(
    parameter int DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // push_byte[7:0], count[14:8], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // opcode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // out_byte[7:0], accepted[8],
                                          // fill_level[19:9], free_space[30:20],
                                          // contiguous[41:31], zero pad
    output logic        o_m_axis_tuser,   // byte_valid
    output logic        o_m_axis_tlast    // last
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                      w_slot_free;
    logic                      w_res_valid;
    brb_pkg::t_result          w_res;
    logic                      w_mem_we;
    logic [PW-1:0]             w_mem_waddr;
    logic [brb_pkg::ByteW-1:0] w_mem_wdata;
    logic                      w_mem_re;
    logic [PW-1:0]             w_mem_raddr;
    logic [brb_pkg::ByteW-1:0] w_mem_rdata;

    logic                      r_m_valid, n_m_valid;
    brb_pkg::t_result          r_m_res, n_m_res;

    brb_ctrl #(
        .DEPTH (DEPTH),
        .PW    (PW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_opcode    (brb_pkg::t_opcode'(i_s_axis_tuser)),
        .i_push_byte (i_s_axis_tdata[7:0]),
        .i_count     (i_s_axis_tdata[14:8]),
        .i_slot_free (w_slot_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    brb_mem #(
        .DEPTH (DEPTH),
        .AW    (PW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // the register can take a new result when empty or draining this cycle
    assign w_slot_free = !r_m_valid || i_m_axis_tready;

    always_comb begin
        n_m_valid = r_m_valid;
        n_m_res   = r_m_res;
        if (w_slot_free) begin
            n_m_valid = w_res_valid;
            if (w_res_valid) begin
                n_m_res = w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_res <= n_m_res;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_m_res.byte_valid;
    assign o_m_axis_tlast  = r_m_res.last;
    assign o_m_axis_tdata  = {6'd0, r_m_res.contiguous, r_m_res.free_space,
                              r_m_res.fill_level, r_m_res.accepted, r_m_res.out_byte};

endmodule

/* src/brb_mem.sv */
// Byte store: one write port, one read port with registered read data.
module brb_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [brb_pkg::ByteW-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [brb_pkg::ByteW-1:0] o_rdata
);

    logic [brb_pkg::ByteW-1:0] r_store [DEPTH];
    logic [brb_pkg::ByteW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_store[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_store[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/brb_ctrl.sv */
// Pointer and fill tracking, operation sequencing and result formation.
module brb_ctrl #(
    parameter int DEPTH = 1024,
    parameter int PW    = 10,
    parameter int CW    = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  brb_pkg::t_opcode           i_opcode,
    input  logic [brb_pkg::ByteW-1:0]  i_push_byte,
    input  logic [brb_pkg::CountW-1:0] i_count,
    input  logic                       i_slot_free,
    output logic                       o_res_valid,
    output brb_pkg::t_result           o_res,
    output logic                       o_mem_we,
    output logic [PW-1:0]              o_mem_waddr,
    output logic [brb_pkg::ByteW-1:0]  o_mem_wdata,
    output logic                       o_mem_re,
    output logic [PW-1:0]              o_mem_raddr,
    input  logic [brb_pkg::ByteW-1:0]  i_mem_rdata
);

    localparam int LW = (CW > brb_pkg::CountW) ? CW : brb_pkg::CountW;
    localparam logic [CW-1:0]   DepthC   = CW'(DEPTH);
    localparam logic [PW:0]     DepthP   = (PW+1)'(DEPTH);
    localparam logic [PW-1:0]   LastPtr  = PW'(DEPTH - 1);
    localparam logic [CW:0]     DepthS   = (CW+1)'(DEPTH);
    localparam logic [LW-1:0]   MaxResL  = LW'(brb_pkg::MaxResults);

    brb_pkg::t_state            r_state, n_state;
    logic [PW-1:0]              r_rp, n_rp;
    logic [PW-1:0]              r_wp, n_wp;
    logic [CW-1:0]              r_fill, n_fill;
    logic [brb_pkg::CountW-1:0] r_left, n_left;

    logic                       w_accept;
    logic [LW-1:0]              w_avail;
    logic [brb_pkg::CountW-1:0] w_pop_n;
    logic [PW:0]                w_drop_sum;
    logic [PW-1:0]              w_drop_rp;
    logic [PW-1:0]              w_rp_inc;
    logic [PW-1:0]              w_wp_inc;
    logic [PW-1:0]              s_rp;
    logic [CW-1:0]              s_fill;
    logic [CW:0]                w_end_sum;
    logic [CW-1:0]              w_contig;

    assign w_avail = (LW'(i_count) < LW'(r_fill)) ? LW'(i_count) : LW'(r_fill);
    assign w_pop_n = (w_avail < MaxResL) ? brb_pkg::CountW'(w_avail)
                                         : brb_pkg::CountW'(MaxResL);
    // w_avail never exceeds the fill, so the sum stays below twice the depth
    assign w_drop_sum = (PW+1)'(r_rp) + (PW+1)'(w_avail);
    assign w_drop_rp  = (w_drop_sum >= DepthP) ? PW'(w_drop_sum - DepthP) : PW'(w_drop_sum);
    assign w_rp_inc   = (r_rp == LastPtr) ? '0 : r_rp + 1'b1;
    assign w_wp_inc   = (r_wp == LastPtr) ? '0 : r_wp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brb_pkg::ST_IDLE;
            r_rp    <= '0;
            r_wp    <= '0;
            r_fill  <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_fill  <= n_fill;
            r_left  <= n_left;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_left      = r_left;
        o_in_ready  = (r_state == brb_pkg::ST_IDLE) && i_slot_free;
        w_accept    = i_in_valid && o_in_ready;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.last  = 1'b1;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        s_rp        = r_rp;
        s_fill      = r_fill;

        case (r_state)
            brb_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_opcode)
                        brb_pkg::OP_PUSH: begin
                            o_res_valid = 1'b1;
                            if (r_fill != DepthC) begin
                                o_mem_we       = 1'b1;
                                n_wp           = w_wp_inc;
                                n_fill         = r_fill + 1'b1;
                                s_fill         = n_fill;
                                o_res.accepted = 1'b1;
                            end
                        end
                        brb_pkg::OP_POP: begin
                            if (w_pop_n == '0) begin
                                o_res_valid = 1'b1;
                            end else begin
                                n_left  = w_pop_n;
                                n_state = brb_pkg::ST_POP_RD;
                            end
                        end
                        brb_pkg::OP_DROP: begin
                            n_rp    = w_drop_rp;
                            n_fill  = r_fill - CW'(w_avail);
                            n_state = brb_pkg::ST_DROP_RESP;
                        end
                        default: begin
                            o_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            brb_pkg::ST_POP_RD: begin
                // consume one byte; its data arrives next cycle
                o_mem_re = 1'b1;
                n_rp     = w_rp_inc;
                n_fill   = r_fill - 1'b1;
                n_left   = r_left - 1'b1;
                n_state  = brb_pkg::ST_POP_WAIT;
            end
            brb_pkg::ST_POP_WAIT: begin
                o_res_valid      = 1'b1;
                o_res.out_byte   = i_mem_rdata;
                o_res.byte_valid = 1'b1;
                o_res.last       = (r_left == '0);
                if (i_slot_free) begin
                    n_state = (r_left == '0) ? brb_pkg::ST_IDLE : brb_pkg::ST_POP_RD;
                end
            end
            brb_pkg::ST_DROP_RESP: begin
                o_res_valid = 1'b1;
                if (i_slot_free) begin
                    n_state = brb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = brb_pkg::ST_IDLE;
            end
        endcase

        // bytes readable before the read pointer wraps
        w_end_sum = (CW+1)'(s_rp) + (CW+1)'(s_fill);
        w_contig  = (w_end_sum >= DepthS) ? CW'(DepthS - (CW+1)'(s_rp)) : s_fill;

        o_res.fill_level = brb_pkg::StatW'(s_fill);
        o_res.free_space = brb_pkg::StatW'(DepthC - s_fill);
        o_res.contiguous = brb_pkg::StatW'(w_contig);
    end

    assign o_mem_waddr = r_wp;
    assign o_mem_wdata = i_push_byte;
    assign o_mem_raddr = r_rp;

    logic [CW:0]   w_chk_sum;
    logic [PW-1:0] w_chk_wp;
    assign w_chk_sum = (CW+1)'(r_rp) + (CW+1)'(r_fill);
    assign w_chk_wp  = (w_chk_sum >= DepthS) ? PW'(w_chk_sum - DepthS) : PW'(w_chk_sum);

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DepthC)
        else $error("fill exceeds depth");

    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp == w_chk_wp)
        else $error("write pointer out of step with read pointer and fill");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == brb_pkg::ST_POP_RD |-> r_fill != '0)
        else $error("pop read issued on empty store");

    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_opcode == brb_pkg::OP_PUSH && r_fill != DepthC)
        |=> r_fill == $past(r_fill) + 1'b1)
        else $error("push did not advance fill");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= brb_pkg::CountW'(brb_pkg::MaxResults))
        else $error("pop byte count out of range");

endmodule
